// File: design/box_downscale_4x4_yuv_rgb_assert.svh
// Assertion macros for the box downscaler
`ifndef BOX_DOWNSCALE_4X4_YUV_RGB_ASSERT_SVH
`define BOX_DOWNSCALE_4X4_YUV_RGB_ASSERT_SVH
`ifndef SYNTHESIS
`define BDYR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdyr assertion failed");
`define BDYR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdyr assertion failed");
`else
`define BDYR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BDYR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/bdyr_pkg.sv
// Shared types and constants of the box downscaler
package bdyr_pkg;

   localparam int PIX_W     = 8;
   localparam int SIZE_W    = 12;
   localparam int POS_W     = 11;
   localparam int LX_W      = 12;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 21;
   localparam int FRAC_BITS = 10;

   localparam logic [SIZE_W-1:0] SIZE_LIMIT    = SIZE_W'(2048);
   localparam logic [SIZE_W-1:0] SIZE_MIN      = SIZE_W'(1);
   localparam logic [SIZE_W-1:0] WIDTH_RESET   = SIZE_W'(1920);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET  = SIZE_W'(1080);
   localparam logic              MODE_RESET    = 1'b1;

   localparam logic signed [PROD_W-1:0] COEF_RV    = PROD_W'(1436);
   localparam logic signed [PROD_W-1:0] COEF_GU    = PROD_W'(352);
   localparam logic signed [PROD_W-1:0] COEF_GV    = PROD_W'(731);
   localparam logic signed [PROD_W-1:0] COEF_BU    = PROD_W'(1815);
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(512);
   localparam logic signed [PROD_W-1:0] CHROMA_OFS = PROD_W'(128);
   localparam logic signed [PROD_W-1:0] PIX_MAX    = PROD_W'(255);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INPUT_MODE   = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] chan_first;
      logic [PIX_W-1:0] chan_second;
      logic [PIX_W-1:0] chan_third;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
      logic             row_done;
      logic             frame_done;
   } rsp_payload_type;

   typedef struct packed {
      logic            in_frame;
      logic            first;
      logic            last;
      logic            row_done;
      logic            frame_done;
      logic [LX_W-1:0] lx;
   } scan_info_type;

   typedef struct packed {
      logic valid;
      logic row_done;
      logic frame_done;
   } blk_flags_type;

endpackage

// File: design/bdyr_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction
interface bdyr_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: design/bdyr_scan.sv
// Raster position counters and block classification of the incoming pixel
module bdyr_scan #(
   parameter int BLOCK_SIZE    = 4,
   parameter int MAX_OUT_WIDTH = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [bdyr_pkg::SIZE_W-1:0]    frame_width,
   input  logic [bdyr_pkg::SIZE_W-1:0]    frame_height,
   output bdyr_pkg::scan_info_type        info
);
   import bdyr_pkg::*;

   localparam int               DX_W     = $clog2(BLOCK_SIZE);
   localparam logic [DX_W-1:0]  D_LAST   = DX_W'(BLOCK_SIZE - 1);
   localparam logic [SIZE_W:0]  SPAN1    = (SIZE_W + 1)'(BLOCK_SIZE);
   localparam logic [SIZE_W:0]  SPAN2    = (SIZE_W + 1)'(2 * BLOCK_SIZE);
   localparam logic [LX_W:0]    KEPT_LIM = (LX_W + 1)'(MAX_OUT_WIDTH);
   localparam logic [LX_W-1:0]  LX_LAST  = LX_W'(MAX_OUT_WIDTH - 1);

   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [POS_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [DX_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [LX_W-1:0]  lx_ff, lx_in;
   logic [SIZE_W:0]  bx_ext, by_ext, w_ext, h_ext;
   logic             col_wrap, row_wrap, row_more, col_more;

   always_comb begin
      bx_ext   = (SIZE_W + 1)'(bx_ff);
      by_ext   = (SIZE_W + 1)'(by_ff);
      w_ext    = (SIZE_W + 1)'(frame_width);
      h_ext    = (SIZE_W + 1)'(frame_height);
      col_more = (bx_ext + SPAN2) <= w_ext;
      row_more = (by_ext + SPAN2) <= h_ext;
      info.in_frame   = ((bx_ext + SPAN1) <= w_ext) && ((by_ext + SPAN1) <= h_ext) &&
                        ((LX_W + 1)'(lx_ff) < KEPT_LIM);
      info.first      = (dx_ff == '0) && (dy_ff == '0);
      info.last       = (dx_ff == D_LAST) && (dy_ff == D_LAST);
      info.row_done   = !col_more || (lx_ff == LX_LAST);
      info.frame_done = info.row_done && !row_more;
      info.lx         = lx_ff;
      col_wrap = (SIZE_W'(col_ff) + SIZE_W'(1)) >= frame_width;
      row_wrap = (SIZE_W'(row_ff) + SIZE_W'(1)) >= frame_height;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      bx_in  = bx_ff;
      by_in  = by_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      lx_in  = lx_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            bx_in  = '0;
            dx_in  = '0;
            lx_in  = '0;
            if (row_wrap) begin
               row_in = '0;
               by_in  = '0;
               dy_in  = '0;
            end else begin
               row_in = row_ff + POS_W'(1);
               if (dy_ff == D_LAST) begin
                  dy_in = '0;
                  by_in = by_ff + POS_W'(BLOCK_SIZE);
               end else begin
                  dy_in = dy_ff + DX_W'(1);
               end
            end
         end else begin
            col_in = col_ff + POS_W'(1);
            if (dx_ff == D_LAST) begin
               dx_in = '0;
               bx_in = bx_ff + POS_W'(BLOCK_SIZE);
               lx_in = lx_ff + LX_W'(1);
            end else begin
               dx_in = dx_ff + DX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         bx_ff  <= '0;
         by_ff  <= '0;
         dx_ff  <= '0;
         dy_ff  <= '0;
         lx_ff  <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         bx_ff  <= bx_in;
         by_ff  <= by_in;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         lx_ff  <= lx_in;
      end
   end

endmodule

// File: design/bdyr_accum.sv
// Column sum memory with read-modify-write and write forwarding
module bdyr_accum #(
   parameter int SUM_W         = 12,
   parameter int MAX_OUT_WIDTH = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             accept,
   input  bdyr_pkg::scan_info_type          info,
   input  bdyr_pkg::req_payload_type        pixel,
   output bdyr_pkg::blk_flags_type          blk_flags,
   output logic [3*SUM_W-1:0]               blk_sums
);
   import bdyr_pkg::*;

   localparam int ADDR_W  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int ENTRY_W = 3 * SUM_W;

   logic [ENTRY_W-1:0] sum_mem [MAX_OUT_WIDTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic               s1_valid_ff;
   scan_info_type      s1_info_ff;
   req_payload_type    s1_pixel_ff;

   logic               fwd_valid_ff;
   logic [ADDR_W-1:0]  fwd_addr_ff;
   logic [ENTRY_W-1:0] fwd_data_ff;

   blk_flags_type      flags_ff;
   logic [ENTRY_W-1:0] sums_ff;

   logic [ADDR_W-1:0]       rd_addr, s1_addr;
   logic [ENTRY_W-1:0]      base, new_sum;
   logic [2:0][PIX_W-1:0]   s1_chan;
   logic                    wr_en;

   always_comb begin
      rd_addr = info.lx[ADDR_W-1:0];
      s1_addr = s1_info_ff.lx[ADDR_W-1:0];
      wr_en   = s1_valid_ff && s1_info_ff.in_frame;
      s1_chan = {s1_pixel_ff.chan_third, s1_pixel_ff.chan_second, s1_pixel_ff.chan_first};
      priority if (s1_info_ff.first) begin
         base = '0;
      end else if (fwd_valid_ff && (fwd_addr_ff == s1_addr)) begin
         base = fwd_data_ff;
      end else begin
         base = rd_data_ff;
      end
      for (int c = 0; c < 3; c++) begin
         new_sum[c*SUM_W +: SUM_W] = base[c*SUM_W +: SUM_W] + SUM_W'(s1_chan[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance && accept && info.in_frame) begin
         rd_data_ff <= sum_mem[rd_addr];
      end
      if (advance && wr_en) begin
         sum_mem[s1_addr] <= new_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else if (advance) begin
         s1_valid_ff         <= accept;
         fwd_valid_ff        <= wr_en;
         flags_ff.valid      <= wr_en && s1_info_ff.last;
         flags_ff.row_done   <= s1_info_ff.row_done;
         flags_ff.frame_done <= s1_info_ff.frame_done;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_info_ff  <= info;
         s1_pixel_ff <= pixel;
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= new_sum;
         sums_ff     <= new_sum;
      end
   end

   assign blk_flags = flags_ff;
   assign blk_sums  = sums_ff;

endmodule

// File: design/bdyr_color.sv
// Rounded block average and optional BT.601 YUV to RGB conversion pipeline
module bdyr_color #(
   parameter int BLOCK_SIZE = 4,
   parameter int SUM_W      = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          input_mode,
   input  bdyr_pkg::blk_flags_type       blk_flags,
   input  logic [3*SUM_W-1:0]            blk_sums,
   output logic                          pix_valid,
   output bdyr_pkg::rsp_payload_type     pix
);
   import bdyr_pkg::*;

   localparam int             NPIX    = BLOCK_SIZE * BLOCK_SIZE;
   localparam int             X_W     = SUM_W + 1;
   localparam int             SHIFT   = X_W + $clog2(NPIX) + 1;
   localparam int             RECIP   = ((1 << SHIFT) + NPIX - 1) / NPIX;
   localparam int             RECIP_W = $clog2(RECIP + 1);
   localparam int             MUL_W   = X_W + RECIP_W;
   localparam logic [X_W-1:0] HALF    = X_W'(NPIX / 2);

   function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [PROD_W-1:0] v);
      logic [PIX_W-1:0] r;
      priority if (v < 0) begin
         r = '0;
      end else if (v > PIX_MAX) begin
         r = '1;
      end else begin
         r = v[PIX_W-1:0];
      end
      return r;
   endfunction

   blk_flags_type                a_flags_ff, b_flags_ff;
   logic [2:0][PIX_W-1:0]        avg_ff, avg_in, luma_ff;
   logic signed [PROD_W-1:0]     r_prod_ff, g_prod_ff, b_prod_ff;
   logic signed [PROD_W-1:0]     r_prod_in, g_prod_in, b_prod_in;
   logic [2:0][MUL_W-1:0]        quot;
   logic signed [PROD_W-1:0]     u_w, v_w, y_w;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         quot[c]   = MUL_W'(blk_sums[c*SUM_W +: SUM_W] + X_W'(HALF)) * MUL_W'(RECIP);
         avg_in[c] = quot[c][SHIFT +: PIX_W];
      end
   end

   always_comb begin
      u_w       = PROD_W'($signed({1'b0, avg_ff[1]})) - CHROMA_OFS;
      v_w       = PROD_W'($signed({1'b0, avg_ff[2]})) - CHROMA_OFS;
      r_prod_in = COEF_RV * v_w + ROUND_HALF;
      g_prod_in = COEF_GU * u_w + COEF_GV * v_w + ROUND_HALF;
      b_prod_in = COEF_BU * u_w + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_flags_ff <= '0;
         b_flags_ff <= '0;
      end else if (advance) begin
         a_flags_ff <= blk_flags;
         b_flags_ff <= a_flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         avg_ff    <= avg_in;
         luma_ff   <= avg_ff;
         r_prod_ff <= r_prod_in;
         g_prod_ff <= g_prod_in;
         b_prod_ff <= b_prod_in;
      end
   end

   always_comb begin
      y_w = PROD_W'($signed({1'b0, luma_ff[0]}));
      if (input_mode) begin
         pix.out_red   = clamp_pix(y_w + (r_prod_ff >>> FRAC_BITS));
         pix.out_green = clamp_pix(y_w - (g_prod_ff >>> FRAC_BITS));
         pix.out_blue  = clamp_pix(y_w + (b_prod_ff >>> FRAC_BITS));
      end else begin
         pix.out_red   = luma_ff[0];
         pix.out_green = luma_ff[1];
         pix.out_blue  = luma_ff[2];
      end
      pix.row_done   = b_flags_ff.row_done;
      pix.frame_done = b_flags_ff.frame_done;
      pix_valid      = b_flags_ff.valid;
   end

endmodule

// File: design/box_downscale_4x4_yuv_rgb.sv
// Top level of the box downscaler with YUV to RGB conversion
// Throughput: one pixel transaction per cycle; input stalls only while a
//   result leaves the conversion pipeline and the output register is held.
// Pipeline: after its last pixel is taken, a block's result is valid once it
//   has passed memory read, accumulate, average, multiply, output register.
// Reset: synchronous; clears position, pipeline and output, loads register
//   defaults. The sum memory is not cleared: a block's first pixel overwrites.
`include "box_downscale_4x4_yuv_rgb_assert.svh"
module box_downscale_4x4_yuv_rgb #(
   parameter int BLOCK_SIZE    = 4,
   parameter int MAX_OUT_WIDTH = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   bdyr_stream_if.sink                      req_chan,
   bdyr_stream_if.source                    rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [bdyr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bdyr_pkg::SIZE_W-1:0]      csr_wr_data
);
   import bdyr_pkg::*;

   localparam int SUM_W = PIX_W + $clog2(BLOCK_SIZE * BLOCK_SIZE);

   logic              mode_ff;
   logic [SIZE_W-1:0] width_ff, height_ff, w_eff, h_eff;

   logic              advance, accept, pix_valid;
   scan_info_type     info;
   blk_flags_type     blk_flags;
   logic [3*SUM_W-1:0] blk_sums;
   rsp_payload_type   pix;

   logic              rsp_valid_ff;
   rsp_payload_type   rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_INPUT_MODE:   mode_ff   <= csr_wr_data[0];
            CSR_FRAME_WIDTH:  width_ff  <= csr_wr_data;
            CSR_FRAME_HEIGHT: height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (width_ff < SIZE_MIN) begin
         w_eff = SIZE_MIN;
      end else if (width_ff > SIZE_LIMIT) begin
         w_eff = SIZE_LIMIT;
      end else begin
         w_eff = width_ff;
      end
      priority if (height_ff < SIZE_MIN) begin
         h_eff = SIZE_MIN;
      end else if (height_ff > SIZE_LIMIT) begin
         h_eff = SIZE_LIMIT;
      end else begin
         h_eff = height_ff;
      end
   end

   assign advance        = !(pix_valid && rsp_valid_ff && !rsp_chan.ready);
   assign accept         = req_chan.valid && advance;
   assign req_chan.ready = advance;

   bdyr_scan #(
      .BLOCK_SIZE    (BLOCK_SIZE),
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .frame_width  (w_eff),
      .frame_height (h_eff),
      .info         (info)
   );

   bdyr_accum #(
      .SUM_W         (SUM_W),
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .accept    (accept),
      .info      (info),
      .pixel     (req_chan.payload),
      .blk_flags (blk_flags),
      .blk_sums  (blk_sums)
   );

   bdyr_color #(
      .BLOCK_SIZE (BLOCK_SIZE),
      .SUM_W      (SUM_W)
   ) u_color (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .input_mode (mode_ff),
      .blk_flags  (blk_flags),
      .blk_sums   (blk_sums),
      .pix_valid  (pix_valid),
      .pix        (pix)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pix_valid && advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_valid && advance) begin
         rsp_data_ff <= pix;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   `BDYR_ASSERT_IMPL(a_frame_ends_row, clock, reset, rsp_valid_ff && rsp_data_ff.frame_done, rsp_data_ff.row_done)
   `BDYR_ASSERT_NEXT(a_result_captured, clock, reset, pix_valid && !(rsp_valid_ff && !rsp_chan.ready), rsp_valid_ff)
   `BDYR_ASSERT_IMPL(a_empty_after_reset, clock, reset, $fell(reset), !rsp_valid_ff && !pix_valid)

endmodule
